FILE: hdl/audio_energy_beat_detector_unit_macros.svh
// assertion macros shared by the beat detector rtl
`ifndef AUDIO_ENERGY_BEAT_DETECTOR_UNIT_MACROS_SVH
`define AUDIO_ENERGY_BEAT_DETECTOR_UNIT_MACROS_SVH

// same-cycle implication, checked at the rising edge, off while in reset
`define AEBD_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("beat detector check failed");

// next-cycle implication
`define AEBD_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("beat detector check failed");

`endif

FILE: hdl/aebd_pkg.sv
// types, constants and widths shared by the beat detector
`timescale 1ns / 1ps
package aebd_pkg;

  localparam int HistoryDepthDef = 64;
  localparam int MaxFramesDef    = 4096;

  localparam int SampleW   = 16;
  localparam int FrameW    = 13;
  localparam int LevelW    = 16;
  localparam int SinceW    = 32;
  localparam int SensW     = 12;
  localparam int HoldW     = 20;
  localparam int DecayW    = 16;
  localparam int ChanW     = 4;
  localparam int CfgIdxW   = 4;
  localparam int CfgDataW  = 20;
  localparam int SumW      = 48;
  localparam int SquareW   = 32;
  localparam int TotalW    = FrameW + ChanW;
  localparam int UnitW     = 64;
  localparam int DivisorW  = 32;
  localparam int RemW      = 36;
  localparam int IterW     = 7;

  localparam logic [SensW-1:0]  SensReset  = 12'd384;
  localparam logic [HoldW-1:0]  HoldReset  = 20'd4800;
  localparam logic [DecayW-1:0] DecayReset = 16'd58982;
  localparam logic [ChanW-1:0]  ChanReset  = 4'd2;

  localparam logic [LevelW-1:0] MinThreshold = 16'd655;
  localparam logic [LevelW-1:0] LevelMax     = 16'hFFFF;

  // register indexes
  localparam logic [CfgIdxW-1:0] RegSensitivity  = 4'd0;
  localparam logic [CfgIdxW-1:0] RegHoldFrames   = 4'd1;
  localparam logic [CfgIdxW-1:0] RegDecayFactor  = 4'd2;
  localparam logic [CfgIdxW-1:0] RegChannelCount = 4'd3;

  typedef enum logic {
    OP_DIV,
    OP_SQRT
  } aebd_op_e;

  typedef struct packed {
    logic                start;
    aebd_op_e            op;
    logic [UnitW-1:0]    a;
    logic [DivisorW-1:0] b;
  } aebd_unit_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [UnitW-1:0] result;
  } aebd_unit_rsp_t;

  typedef enum logic [4:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ACC,
    ST_TOTAL,
    ST_DIV_MS,
    ST_SQRT_MS,
    ST_RING,
    ST_SUM2,
    ST_PROD,
    ST_DIV_AVG,
    ST_SQRT_DEV,
    ST_SCALE,
    ST_DIV_THR,
    ST_DECIDE,
    ST_DIV_PRE,
    ST_MIX,
    ST_BLEND,
    ST_OUT
  } aebd_state_e;

endpackage

FILE: hdl/aebd_if.sv
// stream and configuration channel interfaces
`timescale 1ns / 1ps
interface aebd_in_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [aebd_pkg::SampleW-1:0]    sample;
  logic                                   last_of_buffer;
  logic        [aebd_pkg::FrameW-1:0]     frame_count;
  modport source (output valid, sample, last_of_buffer, frame_count, input ready);
  modport sink   (input valid, sample, last_of_buffer, frame_count, output ready);
endinterface

interface aebd_out_if;
  logic                           valid;
  logic                           ready;
  logic                           beat;
  logic [aebd_pkg::LevelW-1:0]    raw_energy;
  logic [aebd_pkg::LevelW-1:0]    average_energy;
  logic [aebd_pkg::LevelW-1:0]    threshold_level;
  logic [aebd_pkg::LevelW-1:0]    intensity;
  logic [aebd_pkg::LevelW-1:0]    smoothed_energy;
  logic [aebd_pkg::SinceW-1:0]    frames_since_beat;
  modport source (output valid, beat, raw_energy, average_energy, threshold_level,
                  intensity, smoothed_energy, frames_since_beat, input ready);
  modport sink   (input valid, beat, raw_energy, average_energy, threshold_level,
                  intensity, smoothed_energy, frames_since_beat, output ready);
endinterface

interface aebd_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [aebd_pkg::CfgIdxW-1:0]   index;
  logic [aebd_pkg::CfgDataW-1:0]  data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: hdl/aebd_ram.sv
// generic single-port-write ram with registered read
`timescale 1ns / 1ps
module aebd_ram #(
  parameter int Width = 16,
  parameter int Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;
endmodule

FILE: hdl/aebd_div_sqrt.sv
// shared bit-serial divider and square root unit
`timescale 1ns / 1ps
module aebd_div_sqrt (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  aebd_pkg::aebd_unit_req_t req_i,
  output aebd_pkg::aebd_unit_rsp_t rsp_o
);
  localparam int UnitW = aebd_pkg::UnitW;
  localparam int RemW  = aebd_pkg::RemW;
  localparam int IterW = aebd_pkg::IterW;

  logic                busy_q, done_q;
  aebd_pkg::aebd_op_e  op_q;
  logic [UnitW-1:0]    src_q, res_q;
  logic [aebd_pkg::DivisorW-1:0] div_q;
  logic [RemW-1:0]     rem_q;
  logic [IterW-1:0]    cnt_q;

  logic [RemW-1:0] rem_sh, trial;
  logic            ge;
  logic [IterW-1:0] last_cnt;

  always_comb begin
    if (op_q == aebd_pkg::OP_DIV) begin
      rem_sh   = {rem_q[RemW-2:0], src_q[UnitW-1]};
      trial    = RemW'(div_q);
      last_cnt = IterW'(UnitW - 1);
    end else begin
      rem_sh   = {rem_q[RemW-3:0], src_q[UnitW-1 -: 2]};
      trial    = RemW'({res_q[UnitW/2-1:0], 2'b01});
      last_cnt = IterW'(UnitW / 2 - 1);
    end
    ge = (rem_sh >= trial);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == last_cnt) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // datapath: one quotient bit or one root bit a cycle
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      op_q  <= req_i.op;
      src_q <= req_i.a;
      div_q <= req_i.b;
      rem_q <= '0;
      res_q <= '0;
    end else if (busy_q) begin
      rem_q <= ge ? (rem_sh - trial) : rem_sh;
      res_q <= {res_q[UnitW-2:0], ge};
      src_q <= (op_q == aebd_pkg::OP_DIV) ? {src_q[UnitW-2:0], 1'b0}
                                          : {src_q[UnitW-3:0], 2'b00};
    end
  end

  assign rsp_o.busy   = busy_q;
  assign rsp_o.done   = done_q;
  assign rsp_o.result = res_q;
endmodule

FILE: hdl/audio_energy_beat_detector_unit.sv
// beat detector top level: sample accumulation, statistics sequencer, result register
// ordinary sample: the block passes through its accumulate state before it takes the next
// transfer; buffer end: result valid in the same cycle as input ready returns, after a
// 64-step division and two 32-step roots, plus a 64-step division on a beat
// a full result register that is not taken holds the sequencer in its last step
// reset: history ram swept to zero while input is held off, config to defaults
`timescale 1ns / 1ps
`include "audio_energy_beat_detector_unit_macros.svh"
module audio_energy_beat_detector_unit #(
  parameter int HISTORY_DEPTH = aebd_pkg::HistoryDepthDef,
  parameter int MAX_FRAMES    = aebd_pkg::MaxFramesDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  aebd_in_if.sink     in_s,
  aebd_out_if.source  out_m,
  aebd_cfg_if.sink    cfg_s
);
  // history depth is to be a power of two (the block does not check it), so the mean and threshold divisions are shifts
  localparam int IdxW   = $clog2(HISTORY_DEPTH);
  localparam int NW     = IdxW + 1;
  localparam int S1W    = aebd_pkg::LevelW + IdxW;
  localparam int S2W    = 2 * aebd_pkg::LevelW + IdxW;
  localparam int NS2W   = S2W + NW;
  localparam int SrW    = aebd_pkg::SensW + S1W;
  localparam int LevelW = aebd_pkg::LevelW;
  localparam int UnitW  = aebd_pkg::UnitW;
  localparam int FrameW = aebd_pkg::FrameW;
  localparam int SinceW = aebd_pkg::SinceW;
  localparam int HoldW  = aebd_pkg::HoldW;

  // configuration registers, always writable
  logic [aebd_pkg::SensW-1:0]  sens_q;
  logic [HoldW-1:0]            hold_frames_q;
  logic [aebd_pkg::DecayW-1:0] decay_q;
  logic [aebd_pkg::ChanW-1:0]  chan_q;

  assign cfg_s.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sens_q        <= aebd_pkg::SensReset;
      hold_frames_q <= aebd_pkg::HoldReset;
      decay_q       <= aebd_pkg::DecayReset;
      chan_q        <= aebd_pkg::ChanReset;
    end else if (cfg_s.valid) begin
      unique case (cfg_s.index)
        aebd_pkg::RegSensitivity:  sens_q        <= cfg_s.data[aebd_pkg::SensW-1:0];
        aebd_pkg::RegHoldFrames:   hold_frames_q <= cfg_s.data[HoldW-1:0];
        aebd_pkg::RegDecayFactor:  decay_q       <= cfg_s.data[aebd_pkg::DecayW-1:0];
        aebd_pkg::RegChannelCount: chan_q        <= cfg_s.data[aebd_pkg::ChanW-1:0];
        default: ;
      endcase
    end
  end

  // sequencer
  aebd_pkg::aebd_state_e state_q, state_d;
  logic launch_q, launch_d;
  logic load_out;
  aebd_pkg::aebd_unit_req_t req;
  aebd_pkg::aebd_unit_rsp_t rsp;

  logic [IdxW-1:0] clr_q, pos_q;
  logic            last_q;
  logic [FrameW-1:0] fc_q, frames_q;
  logic [aebd_pkg::SquareW-1:0] sq_q;
  logic [aebd_pkg::SumW-1:0]    sum_q, acc_q, sum_sat;
  logic [aebd_pkg::SumW:0]      sum_ext;
  logic [aebd_pkg::TotalW-1:0]  total_q;
  logic [UnitW-1:0]  ms_q;
  logic [LevelW-1:0] raw_q, old_e, avg_q, thr_q, int_q, env_q;
  logic [S1W-1:0]    s1_q, r_q;
  logic [S2W-1:0]    s2_q;
  logic [2*LevelW-1:0] esq_q, osq_q;
  logic [NS2W-1:0]   ns2_q;
  logic [2*S1W-1:0]  s1sq_q;
  logic [SrW-1:0]    sr_q;
  logic [SrW:0]      thr_sum, thr_quo;
  logic [LevelW:0]   pre_q;
  logic [2*LevelW:0] intp_q, envp2_q;
  logic [2*LevelW-1:0] envp1_q;
  logic [2*LevelW+1:0] env_mix;
  logic [HoldW-1:0]  hold_q, hold_new;
  logic [SinceW-1:0] since_q, since_new;
  logic [SinceW:0]   since_sum;
  logic              beat_q, beat_now;
  logic [aebd_pkg::ChanW-1:0] chan_eff;
  logic              out_valid_q;

  assign chan_eff = (chan_q == '0) ? aebd_pkg::ChanW'(1) : chan_q;

  // saturating square accumulation
  assign sum_ext = {1'b0, sum_q} + (aebd_pkg::SumW + 1)'(sq_q);
  assign sum_sat = sum_ext[aebd_pkg::SumW] ? '1 : sum_ext[aebd_pkg::SumW-1:0];

  // hold and frame counters advanced by the buffer's frames
  assign hold_new  = (hold_q > HoldW'(frames_q)) ? (hold_q - HoldW'(frames_q)) : '0;
  assign since_sum = {1'b0, since_q} + (SinceW + 1)'(frames_q);
  assign since_new = since_sum[SinceW] ? '1 : since_sum[SinceW-1:0];
  assign beat_now  = (raw_q > thr_q) && (hold_new == '0);
  assign env_mix   = (2*LevelW+2)'(envp1_q) + (2*LevelW+2)'(envp2_q);

  // threshold: (256*s1 + sens*dev) / (256*depth), a plain shift
  assign thr_sum = (SrW + 1)'({s1_q, 8'h00}) + (SrW + 1)'(sr_q);
  assign thr_quo = thr_sum >> (8 + IdxW);

  assign in_s.ready = (state_q == aebd_pkg::ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= aebd_pkg::ST_CLEAR;
      launch_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      launch_q <= launch_d;
    end
  end

  always_comb begin
    state_d  = state_q;
    launch_d = 1'b0;
    load_out = 1'b0;
    unique case (state_q)
      aebd_pkg::ST_CLEAR:
        if (clr_q == IdxW'(HISTORY_DEPTH - 1)) state_d = aebd_pkg::ST_IDLE;
      aebd_pkg::ST_IDLE:
        if (in_s.valid) state_d = aebd_pkg::ST_ACC;
      aebd_pkg::ST_ACC:
        if (!last_q || fc_q == '0) state_d = aebd_pkg::ST_IDLE;
        else state_d = aebd_pkg::ST_TOTAL;
      aebd_pkg::ST_TOTAL: begin
        state_d  = aebd_pkg::ST_DIV_MS;
        launch_d = 1'b1;
      end
      aebd_pkg::ST_DIV_MS:
        if (rsp.done) begin
          state_d  = aebd_pkg::ST_SQRT_MS;
          launch_d = 1'b1;
        end
      aebd_pkg::ST_SQRT_MS:
        if (rsp.done) state_d = aebd_pkg::ST_RING;
      aebd_pkg::ST_RING:  state_d = aebd_pkg::ST_SUM2;
      aebd_pkg::ST_SUM2:  state_d = aebd_pkg::ST_PROD;
      aebd_pkg::ST_PROD:  state_d = aebd_pkg::ST_DIV_AVG;
      aebd_pkg::ST_DIV_AVG: begin
        state_d  = aebd_pkg::ST_SQRT_DEV;
        launch_d = 1'b1;
      end
      aebd_pkg::ST_SQRT_DEV:
        if (rsp.done) state_d = aebd_pkg::ST_SCALE;
      aebd_pkg::ST_SCALE:   state_d = aebd_pkg::ST_DIV_THR;
      aebd_pkg::ST_DIV_THR: state_d = aebd_pkg::ST_DECIDE;
      aebd_pkg::ST_DECIDE:
        if (beat_now) begin
          state_d  = aebd_pkg::ST_DIV_PRE;
          launch_d = 1'b1;
        end else begin
          state_d = aebd_pkg::ST_MIX;
        end
      aebd_pkg::ST_DIV_PRE:
        if (rsp.done) state_d = aebd_pkg::ST_MIX;
      aebd_pkg::ST_MIX:   state_d = aebd_pkg::ST_BLEND;
      aebd_pkg::ST_BLEND: state_d = aebd_pkg::ST_OUT;
      aebd_pkg::ST_OUT:
        // result register frees when empty or being taken this cycle
        if (!out_valid_q || out_m.ready) begin
          load_out = 1'b1;
          state_d  = aebd_pkg::ST_IDLE;
        end
      default: state_d = aebd_pkg::ST_IDLE;
    endcase
  end

  // operand selection for the shared unit
  always_comb begin
    req.start = launch_q;
    req.op    = aebd_pkg::OP_DIV;
    req.a     = '0;
    req.b     = '0;
    case (state_q)
      aebd_pkg::ST_DIV_MS: begin
        req.a = UnitW'({acc_q, 2'b00});
        req.b = aebd_pkg::DivisorW'(total_q);
      end
      aebd_pkg::ST_SQRT_MS: begin
        req.op = aebd_pkg::OP_SQRT;
        req.a  = ms_q;
      end
      aebd_pkg::ST_SQRT_DEV: begin
        req.op = aebd_pkg::OP_SQRT;
        req.a  = UnitW'(ns2_q) - UnitW'(s1sq_q);
      end
      aebd_pkg::ST_DIV_PRE: begin
        req.a = UnitW'({raw_q, 16'h0000});
        req.b = aebd_pkg::DivisorW'(thr_q);
      end
      default: ;
    endcase
  end

  aebd_div_sqrt u_unit (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .rsp_o  (rsp)
  );

  // energy history
  logic            ram_we, ram_re;
  logic [IdxW-1:0] ram_waddr;
  logic [LevelW-1:0] ram_wdata;

  assign ram_we    = (state_q == aebd_pkg::ST_CLEAR) || (state_q == aebd_pkg::ST_RING);
  assign ram_waddr = (state_q == aebd_pkg::ST_CLEAR) ? clr_q : pos_q;
  assign ram_wdata = (state_q == aebd_pkg::ST_CLEAR) ? '0 : raw_q;
  assign ram_re    = (state_q == aebd_pkg::ST_TOTAL);

  aebd_ram #(
    .Width (LevelW),
    .Depth (HISTORY_DEPTH)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (pos_q),
    .rdata_o (old_e)
  );

  // control state of the detector
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q   <= '0;
      pos_q   <= '0;
      sum_q   <= '0;
      s1_q    <= '0;
      s2_q    <= '0;
      hold_q  <= '0;
      since_q <= '0;
      int_q   <= '0;
      env_q   <= '0;
    end else begin
      case (state_q)
        aebd_pkg::ST_CLEAR: clr_q <= clr_q + 1'b1;
        aebd_pkg::ST_ACC:   sum_q <= last_q ? '0 : sum_sat;
        aebd_pkg::ST_RING: begin
          // running sums replace the evicted entry with the new one
          s1_q  <= s1_q + S1W'(raw_q) - S1W'(old_e);
          pos_q <= (pos_q == IdxW'(HISTORY_DEPTH - 1)) ? '0 : pos_q + 1'b1;
        end
        aebd_pkg::ST_SUM2: s2_q <= s2_q + S2W'(esq_q) - S2W'(osq_q);
        aebd_pkg::ST_DECIDE: begin
          hold_q  <= beat_now ? hold_frames_q : hold_new;
          since_q <= beat_now ? '0 : since_new;
        end
        aebd_pkg::ST_BLEND: begin
          int_q <= intp_q[2*LevelW-1:LevelW];
          env_q <= (raw_q > env_q) ? raw_q : env_mix[2*LevelW-1:LevelW];
        end
        default: ;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      aebd_pkg::ST_IDLE:
        if (in_s.valid) begin
          sq_q   <= aebd_pkg::SquareW'($unsigned(aebd_pkg::SquareW'(in_s.sample) *
                                                 aebd_pkg::SquareW'(in_s.sample)));
          last_q <= in_s.last_of_buffer;
          fc_q   <= in_s.frame_count;
        end
      aebd_pkg::ST_ACC: begin
        acc_q    <= sum_sat;
        frames_q <= (32'(fc_q) > 32'(MAX_FRAMES)) ? FrameW'(MAX_FRAMES) : fc_q;
      end
      aebd_pkg::ST_TOTAL:
        total_q <= aebd_pkg::TotalW'(frames_q) * aebd_pkg::TotalW'(chan_eff);
      aebd_pkg::ST_DIV_MS:
        if (rsp.done) ms_q <= rsp.result;
      aebd_pkg::ST_SQRT_MS:
        if (rsp.done) begin
          raw_q <= (rsp.result > UnitW'(aebd_pkg::LevelMax)) ? aebd_pkg::LevelMax
                                                             : rsp.result[LevelW-1:0];
        end
      aebd_pkg::ST_RING: begin
        esq_q <= raw_q * raw_q;
        osq_q <= old_e * old_e;
      end
      aebd_pkg::ST_PROD: begin
        ns2_q  <= NS2W'(s2_q) * NS2W'(HISTORY_DEPTH);
        s1sq_q <= s1_q * s1_q;
      end
      aebd_pkg::ST_DIV_AVG: avg_q <= LevelW'(s1_q >> IdxW);
      aebd_pkg::ST_SQRT_DEV:
        if (rsp.done) r_q <= rsp.result[S1W-1:0];
      aebd_pkg::ST_SCALE: sr_q <= SrW'(sens_q) * SrW'(r_q);
      aebd_pkg::ST_DIV_THR:
        if (thr_quo > (SrW + 1)'(aebd_pkg::LevelMax)) thr_q <= aebd_pkg::LevelMax;
        else if (thr_quo < (SrW + 1)'(aebd_pkg::MinThreshold))
          thr_q <= aebd_pkg::MinThreshold;
        else thr_q <= thr_quo[LevelW-1:0];
      aebd_pkg::ST_DECIDE: begin
        beat_q <= beat_now;
        if (!beat_now) pre_q <= (LevelW + 1)'(int_q);
      end
      aebd_pkg::ST_DIV_PRE:
        // ratio is above one here, so the offset never wraps
        if (rsp.done) begin
          pre_q <= ((rsp.result - UnitW'(32768)) > UnitW'(65536))
                   ? (LevelW + 1)'(65536)
                   : (LevelW + 1)'(rsp.result - UnitW'(32768));
        end
      aebd_pkg::ST_MIX: begin
        intp_q  <= (2*LevelW + 1)'(pre_q) * (2*LevelW + 1)'(decay_q);
        envp1_q <= env_q * decay_q;
        envp2_q <= (2*LevelW + 1)'(raw_q) *
                   ((2*LevelW + 1)'(65536) - (2*LevelW + 1)'(decay_q));
      end
      default: ;
    endcase
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_m.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_m.beat              <= beat_q;
      out_m.raw_energy        <= raw_q;
      out_m.average_energy    <= avg_q;
      out_m.threshold_level   <= thr_q;
      out_m.intensity         <= int_q;
      out_m.smoothed_energy   <= env_q;
      out_m.frames_since_beat <= since_q;
    end
  end

  assign out_m.valid = out_valid_q;

  // a new sample is only taken while the sequencer is parked
  `AEBD_ASSERT_IMP(a_ready_idle, clk_i, rst_ni, in_s.ready, state_q == aebd_pkg::ST_IDLE && !rsp.busy)
  // a beat always restarts the frame count
  `AEBD_ASSERT_IMP(a_beat_since, clk_i, rst_ni, out_m.valid && out_m.beat, out_m.frames_since_beat == '0)
  // the threshold never drops below its floor
  `AEBD_ASSERT_IMP(a_thr_floor, clk_i, rst_ni, out_m.valid, out_m.threshold_level >= aebd_pkg::MinThreshold)
  // a finished result is held until taken
  `AEBD_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_m.valid && !out_m.ready, out_m.valid)
endmodule

FILE: dv/tb_audio_energy_beat_detector_unit.sv
// self-checking testbench for the audio energy beat detector
`timescale 1ns / 1ps
module tb_audio_energy_beat_detector_unit;

  // one completed buffer as seen on the result channel
  typedef struct {
    bit                        beat;
    bit [aebd_pkg::LevelW-1:0] raw_energy;
    bit [aebd_pkg::LevelW-1:0] average_energy;
    bit [aebd_pkg::LevelW-1:0] threshold_level;
    bit [aebd_pkg::LevelW-1:0] intensity;
    bit [aebd_pkg::LevelW-1:0] smoothed_energy;
    bit [aebd_pkg::SinceW-1:0] frames_since_beat;
  } beat_report_t;

  // predicts the block's statistics and checks reports in order
  class beat_scoreboard;
    localparam int RingDepth = aebd_pkg::HistoryDepthDef;
    localparam bit [63:0] SquareSumMax = 64'hFFFF_FFFF_FFFF;

    bit [aebd_pkg::SensW-1:0]  sens;
    bit [aebd_pkg::HoldW-1:0]  hold_cfg;
    bit [aebd_pkg::DecayW-1:0] decay;
    bit [aebd_pkg::ChanW-1:0]  chans;

    bit [63:0]                 square_acc;
    bit [aebd_pkg::LevelW-1:0] energy_hist [RingDepth];
    int                        hist_pos;
    bit [aebd_pkg::HoldW-1:0]  hold_cnt;
    bit [aebd_pkg::SinceW-1:0] since_cnt;
    bit [aebd_pkg::LevelW-1:0] intens;
    bit [aebd_pkg::LevelW-1:0] envel;

    beat_report_t pending_reports [$];
    int n_errors;
    int n_checked;
    int n_beats;

    function new();
      sens = aebd_pkg::SensReset;
      hold_cfg = aebd_pkg::HoldReset;
      decay = aebd_pkg::DecayReset;
      chans = aebd_pkg::ChanReset;
      square_acc = 0;
      foreach (energy_hist[i]) energy_hist[i] = 0;
      hist_pos = 0;
      hold_cnt = 0;
      since_cnt = 0;
      intens = 0;
      envel = 0;
    endfunction

    function void set_reg(logic [aebd_pkg::CfgIdxW-1:0] idx, bit [aebd_pkg::CfgDataW-1:0] val);
      case (idx)
        aebd_pkg::RegSensitivity:  sens = val[aebd_pkg::SensW-1:0];
        aebd_pkg::RegHoldFrames:   hold_cfg = val[aebd_pkg::HoldW-1:0];
        aebd_pkg::RegDecayFactor:  decay = val[aebd_pkg::DecayW-1:0];
        aebd_pkg::RegChannelCount: chans = val[aebd_pkg::ChanW-1:0];
        default: ;
      endcase
    endfunction

    // floor square root, result below 2^32
    function bit [63:0] root_down(bit [63:0] v);
      bit [63:0] r;
      bit [63:0] t;
      r = 0;
      for (int b = 31; b >= 0; b--) begin
        t = r | (64'd1 << b);
        if (t * t <= v) r = t;
      end
      return r;
    endfunction

    function void note_input(logic signed [aebd_pkg::SampleW-1:0] smp, bit last,
                             bit [aebd_pkg::FrameW-1:0] fc);
      longint    sv;
      bit [63:0] sq, total, fr, ch, ms, raw, s1, s2, dev, thr, pre, env_mix;
      beat_report_t rep;
      sv = smp;
      sq = sv * sv;
      square_acc = (square_acc > SquareSumMax - sq) ? SquareSumMax : square_acc + sq;
      if (!last) return;
      total = square_acc;
      square_acc = 0;
      // zero-frame buffer only clears the sum
      if (fc == 0) return;
      fr = (fc > aebd_pkg::MaxFramesDef) ? 64'(aebd_pkg::MaxFramesDef) : 64'(fc);
      ch = (chans == 0) ? 64'd1 : 64'(chans);
      ms = (total << 2) / (fr * ch);
      raw = root_down(ms);
      if (raw > aebd_pkg::LevelMax) raw = 64'(aebd_pkg::LevelMax);
      energy_hist[hist_pos] = raw[aebd_pkg::LevelW-1:0];
      hist_pos = (hist_pos + 1) % RingDepth;
      s1 = 0;
      s2 = 0;
      foreach (energy_hist[i]) begin
        s1 += energy_hist[i];
        s2 += 64'(energy_hist[i]) * energy_hist[i];
      end
      dev = root_down(RingDepth * s2 - s1 * s1);
      thr = (s1 * 256 + 64'(sens) * dev) / (256 * RingDepth);
      if (thr > aebd_pkg::LevelMax) thr = 64'(aebd_pkg::LevelMax);
      if (thr < aebd_pkg::MinThreshold) thr = 64'(aebd_pkg::MinThreshold);
      hold_cnt = (hold_cnt > fr) ? hold_cnt - fr[aebd_pkg::HoldW-1:0] : '0;
      since_cnt = (64'(since_cnt) + fr > 64'hFFFF_FFFF) ? '1
                                                        : since_cnt + fr[aebd_pkg::SinceW-1:0];
      pre = intens;
      rep.beat = 0;
      if (raw > thr && hold_cnt == 0) begin
        rep.beat = 1;
        hold_cnt = hold_cfg;
        since_cnt = 0;
        pre = (raw * 65536) / thr - 32768;
        if (pre > 65536) pre = 65536;
        n_beats++;
      end
      intens = aebd_pkg::LevelW'((pre * decay) >> 16);
      if (raw > envel) begin
        envel = raw[aebd_pkg::LevelW-1:0];
      end else begin
        env_mix = 64'(envel) * decay + raw * (65536 - 64'(decay));
        envel = aebd_pkg::LevelW'(env_mix >> 16);
      end
      rep.raw_energy = raw[aebd_pkg::LevelW-1:0];
      rep.average_energy = aebd_pkg::LevelW'(s1 / RingDepth);
      rep.threshold_level = thr[aebd_pkg::LevelW-1:0];
      rep.intensity = intens;
      rep.smoothed_energy = envel;
      rep.frames_since_beat = since_cnt;
      pending_reports.push_back(rep);
    endfunction

    function void flag(string what, longint unsigned want, longint unsigned got);
      n_errors++;
      if (n_errors <= 10)
        $display("mismatch %s: expected %0d, got %0d (report %0d)", what, want, got, n_checked);
    endfunction

    function void check_report(beat_report_t got);
      beat_report_t want;
      if (pending_reports.size() == 0) begin
        n_errors++;
        if (n_errors <= 10) $display("unexpected report, raw_energy %0d", got.raw_energy);
        return;
      end
      want = pending_reports.pop_front();
      if (got.beat != want.beat) flag("beat", want.beat, got.beat);
      if (got.raw_energy != want.raw_energy) flag("raw_energy", want.raw_energy, got.raw_energy);
      if (got.average_energy != want.average_energy)
        flag("average_energy", want.average_energy, got.average_energy);
      if (got.threshold_level != want.threshold_level)
        flag("threshold_level", want.threshold_level, got.threshold_level);
      if (got.intensity != want.intensity) flag("intensity", want.intensity, got.intensity);
      if (got.smoothed_energy != want.smoothed_energy)
        flag("smoothed_energy", want.smoothed_energy, got.smoothed_energy);
      if (got.frames_since_beat != want.frames_since_beat)
        flag("frames_since_beat", want.frames_since_beat, got.frames_since_beat);
      n_checked++;
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  aebd_in_if  in_if ();
  aebd_out_if out_if ();
  aebd_cfg_if cfg_if ();

  audio_energy_beat_detector_unit DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_s   (in_if),
    .out_m  (out_if),
    .cfg_s  (cfg_if)
  );

  beat_scoreboard sb = new();

  // stimulus bookkeeping
  int  n_samples_sent;
  int  n_buffers_sent;
  bit  sender_calm;      // no gaps on the input side while set
  bit  receiver_calm;    // no stalls on the result side while set
  bit  hold_off_req;     // asks the receiver for one long stall
  int  hold_off_left;
  int  stall_left;

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // watchdog, well beyond the slowest legal run
  initial begin
    #40ms;
    $display("timeout with %0d reports outstanding", sb.pending_reports.size());
    $display("tb_audio_energy_beat_detector_unit: FAIL");
    $finish;
  end

  // transfer monitor: results checked before new inputs are noted
  always @(posedge clk_i) begin
    beat_report_t got;
    if (rst_ni) begin
      if (out_if.valid && out_if.ready) begin
        got.beat = out_if.beat;
        got.raw_energy = out_if.raw_energy;
        got.average_energy = out_if.average_energy;
        got.threshold_level = out_if.threshold_level;
        got.intensity = out_if.intensity;
        got.smoothed_energy = out_if.smoothed_energy;
        got.frames_since_beat = out_if.frames_since_beat;
        sb.check_report(got);
      end
      if (in_if.valid && in_if.ready)
        sb.note_input(in_if.sample, in_if.last_of_buffer, in_if.frame_count);
    end
  end

  // result side: random stalls, calm stretches, and one long hold-off on request
  initial begin
    out_if.ready = 1'b0;
    hold_off_left = 0;
    stall_left = 0;
    forever begin
      @(posedge clk_i);
      if (hold_off_req && hold_off_left == 0) begin
        hold_off_left = 3000;
        hold_off_req = 0;
      end
      if (hold_off_left > 0) begin
        out_if.ready <= 1'b0;
        hold_off_left--;
      end else if (stall_left > 0) begin
        out_if.ready <= 1'b0;
        stall_left--;
      end else begin
        out_if.ready <= 1'b1;
        if (!receiver_calm && $urandom_range(0, 5) == 0)
          stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 3);
      end
    end
  end

  function automatic int pick_gap();
    if (sender_calm || $urandom_range(0, 2) != 0) return 0;
    return ($urandom_range(0, 9) == 0) ? $urandom_range(15, 60) : $urandom_range(1, 3);
  endfunction

  // one sample transfer; valid stays up across back-to-back transfers
  task automatic send_sample(logic signed [aebd_pkg::SampleW-1:0] smp, bit last,
                             bit [aebd_pkg::FrameW-1:0] fc, int gap);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.sample <= smp;
    in_if.last_of_buffer <= last;
    in_if.frame_count <= fc;
    do @(posedge clk_i); while (!in_if.ready);
    n_samples_sent++;
    if (last) n_buffers_sent++;
  endtask

  task automatic wait_reports_drained();
    do @(posedge clk_i); while (sb.pending_reports.size() != 0);
  endtask

  // register write while the block is idle
  task automatic write_reg(logic [aebd_pkg::CfgIdxW-1:0] idx, bit [aebd_pkg::CfgDataW-1:0] val);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data <= val;
    do @(posedge clk_i); while (!cfg_if.ready);
    sb.set_reg(idx, val);
  endtask

  task automatic set_phase(bit [aebd_pkg::SensW-1:0] s, bit [aebd_pkg::HoldW-1:0] h,
                           bit [aebd_pkg::DecayW-1:0] d, bit [aebd_pkg::ChanW-1:0] c);
    in_if.valid <= 1'b0;
    wait_reports_drained();
    repeat (400) @(posedge clk_i);
    write_reg(aebd_pkg::RegSensitivity, s);
    write_reg(aebd_pkg::RegHoldFrames, h);
    write_reg(aebd_pkg::RegDecayFactor, d);
    write_reg(aebd_pkg::RegChannelCount, c);
    cfg_if.valid <= 1'b0;
  endtask

  // random buffer: mostly well-formed short buffers, loudness varying so beats occur
  task automatic random_buffer();
    int n_smp;
    int amp;
    int sel;
    bit [aebd_pkg::FrameW-1:0] fc;
    sel = $urandom_range(0, 99);
    n_smp = (sel < 85) ? $urandom_range(1, 6) : $urandom_range(7, 40);
    case ($urandom_range(0, 9))
      0, 1, 2, 3: amp = $urandom_range(0, 200);
      4, 5, 6:    amp = $urandom_range(200, 3000);
      7, 8:       amp = $urandom_range(3000, 20000);
      default:    amp = 32768;
    endcase
    sel = $urandom_range(0, 99);
    if (sel < 75)      fc = aebd_pkg::FrameW'($urandom_range(1, 8));
    else if (sel < 82) fc = '0;
    else if (sel < 90) fc = aebd_pkg::FrameW'($urandom_range(9, 400));
    else if (sel < 95) fc = aebd_pkg::FrameW'(4096);
    else               fc = aebd_pkg::FrameW'($urandom_range(4097, 8191));
    for (int i = 0; i < n_smp; i++) begin
      int v;
      v = $urandom_range(0, 2 * amp) - amp;
      if (v > 32767) v = 32767;
      // the unflagged samples also carry random frame counts, which must be ignored
      send_sample(v[aebd_pkg::SampleW-1:0], i == n_smp - 1,
                  (i == n_smp - 1) ? fc : aebd_pkg::FrameW'($urandom_range(0, 8191)),
                  pick_gap());
    end
  endtask

  task automatic random_phase(int n_items);
    int start;
    start = n_samples_sent;
    while (n_samples_sent - start < n_items) begin
      if ($urandom_range(0, 19) == 0) sender_calm = !sender_calm;
      if ($urandom_range(0, 19) == 0) receiver_calm = !receiver_calm;
      random_buffer();
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    in_if.valid = 1'b0;
    in_if.sample = '0;
    in_if.last_of_buffer = 1'b0;
    in_if.frame_count = '0;
    cfg_if.valid = 1'b0;
    cfg_if.index = '0;
    cfg_if.data = '0;
    sender_calm = 0;
    receiver_calm = 0;
    hold_off_req = 0;
    n_samples_sent = 0;
    n_buffers_sent = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed part under reset settings: extremes of sample and frame count
    send_sample(16'sh8000, 1'b1, 13'd1, 0);
    send_sample(16'sh7FFF, 1'b1, 13'd1, 0);
    send_sample(16'sh0000, 1'b1, 13'd1, 0);
    send_sample(16'sh0001, 1'b0, 13'h1FFF, 0);
    send_sample(-16'sd1, 1'b1, 13'd4096, 0);
    send_sample(16'sh5555, 1'b1, 13'd0, 0);                // zero frames, no report
    send_sample(16'sh2AAA, 1'b1, 13'd4097, 0);             // clamped frame count
    send_sample(16'sh7FFF, 1'b0, 13'd0, 1);
    send_sample(16'sh8000, 1'b0, 13'd0, 0);
    send_sample(16'sh4000, 1'b1, 13'h1FFF, 0);
    send_sample(16'sh0100, 1'b1, 13'd3, 2);
    send_sample(16'sh7000, 1'b1, 13'd1, 0);                // loud burst after quiet
    send_sample(16'sh0010, 1'b1, 13'd2, 0);
    send_sample(16'sh7FFF, 1'b1, 13'd1, 0);

    // one channel, no hold, zero decay and sensitivity: raw energy saturation
    set_phase(12'd0, 20'd0, 16'd0, 4'd1);
    send_sample(16'sh8000, 1'b1, 13'd1, 0);
    send_sample(16'sh0000, 1'b1, 13'd1, 0);
    send_sample(16'sh8000, 1'b1, 13'd1, 0);
    random_phase(150);

    // other extremes: maximum sensitivity, hold and decay, eight channels
    set_phase(12'd4095, 20'hFFFFF, 16'hFFFF, 4'd8);
    random_phase(150);

    // channel count zero; long receiver hold-off while inputs keep coming
    set_phase(12'd256, 20'd8, 16'd32768, 4'd0);
    hold_off_req = 1;
    random_phase(200);
    // sender pauses until every report is in
    in_if.valid <= 1'b0;
    wait_reports_drained();
    random_phase(50);

    // channel count above eight is taken as given
    set_phase(12'd128, 20'd3, 16'd60000, 4'd15);
    random_phase(200);

    set_phase(12'd384, 20'd20, 16'd58982, 4'd2);
    random_phase(200);

    in_if.valid <= 1'b0;
    wait_reports_drained();
    repeat (400) @(posedge clk_i);

    $display("covered %0d sample transfers in %0d flagged buffers, six register settings",
             n_samples_sent, n_buffers_sent);
    $display("checked %0d reports, %0d with a beat, %0d mismatches",
             sb.n_checked, sb.n_beats, sb.n_errors);
    if (sb.n_errors == 0 && sb.pending_reports.size() == 0) begin
      $display("tb_audio_energy_beat_detector_unit: PASS");
    end else begin
      $display("tb_audio_energy_beat_detector_unit: FAIL");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+hdl
hdl/aebd_pkg.sv
hdl/aebd_if.sv
hdl/aebd_ram.sv
hdl/aebd_div_sqrt.sv
hdl/audio_energy_beat_detector_unit.sv
dv/tb_audio_energy_beat_detector_unit.sv
